>>> design/sirt_pkg.sv
// Package for the signed integer to radix text block: sizes, codes and state type.
`timescale 1ns / 1ps
package sirt_pkg;

    // Symbol slots in the alphabet and width of a slot index
    localparam int SLOTS  = 32;
    localparam int IDX_W  = 5;
    // Digit store depth: a 33-bit magnitude in radix 2 has 33 digits
    localparam int DIGITS = 33;
    localparam int ND_W   = 6;
    // Magnitude width and bit counter width
    localparam int MAG_W  = 33;
    localparam int BIT_W  = 6;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD3 = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_RD,
        ST_EMIT
    } t_state;

endpackage

>>> design/sirt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sirt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/signed_int_to_custom_radix_text.sv
// Top level: signed 32-bit integer to text in a configured radix and alphabet.
`timescale 1ns / 1ps
// Usage
//   Input stream s_axis: one transfer carries one signed 32-bit value in tdata.
//   Output stream m_axis: one transfer per character, most significant digit
//   first, preceded by '-' for a negative value; tlast marks the final one.
//   Config port: write radix_size (index 0) and alphabet words 0..3 (1..4)
//   while idle. Each write starts an alphabet check sweep over every slot,
//   during which s_axis_tready is low. An invalid alphabet makes every value
//   produce no characters.
// Conversion
//   Each digit comes from a bit-serial restoring division of the 33-bit
//   magnitude by the radix. Digits go to a small RAM and are read back in
//   reverse, one read state and one emit state per character. The next value
//   is taken only after the last character has been loaded into the output
//   register.
// Reset
//   Synchronous, active low. Clears the control and configuration registers,
//   so the alphabet is invalid until configured. No clearing pass is needed.
// Back-pressure
//   A stalled m_axis holds the output register; the sequencer waits on it and
//   nothing is lost. A new value may be taken while the last character waits.
module signed_int_to_custom_radix_text #(
    parameter int MAX_RADIX = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [63:0]                       i_cfg_data,
    // Input stream, tdata: [31:0] value
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,
    // Output stream, tdata: [7:0] character; tlast: last
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,
    output logic                              m_axis_tlast
);

    import sirt_pkg::*;

    // Configuration registers
    logic [5:0]            r_radix;
    logic [4*64-1:0]       r_alph;

    // Alphabet check sweep
    logic                  r_chk_busy;
    logic [IDX_W-1:0]      r_chk_idx;
    logic                  r_chk_ok;
    logic                  r_alpha_ok;

    // Conversion sequencer
    t_state                r_state, n_state;
    logic [MAG_W-1:0]      r_quo, n_quo;
    logic [IDX_W-1:0]      r_rem, n_rem;
    logic [BIT_W-1:0]      r_bit;
    logic [ND_W-1:0]       r_nd;
    logic                  r_neg;

    // Output register
    logic                  r_out_valid;
    logic [7:0]            r_out_char;
    logic                  r_out_last;

    // Controls
    logic                  in_ready, in_xfer, out_free, out_load;
    logic [7:0]            load_char;
    logic                  load_last;
    logic                  bit_last, div_done, ram_we;
    logic [5:0]            rem_sh;
    logic                  q_bit;
    logic [MAG_W-1:0]      mag_in;
    logic [7:0]            ram_wdata, ram_rdata;
    logic [ND_W-1:0]       ram_raddr;
    logic                  chk_step_ok, radix_bad;
    logic [7:0]            chk_sym;

    // Pick one alphabet symbol
    function automatic logic [7:0] sym_at(input logic [4*64-1:0] alph,
                                          input logic [IDX_W-1:0] idx);
        sym_at = alph[{idx, 3'b000} +: 8];
    endfunction

    // ---------------- alphabet check ----------------
    assign radix_bad = (r_radix < 6'd2) || (int'(r_radix) > MAX_RADIX)
                     || (int'(r_radix) > SLOTS);
    assign chk_sym   = sym_at(r_alph, r_chk_idx);

    // Reject a swept symbol within the radix that is '+' or '-' or equals a later symbol within the radix
    always_comb begin
        chk_step_ok = 1'b1;
        if ({1'b0, r_chk_idx} < r_radix) begin
            if (chk_sym == CHAR_PLUS || chk_sym == CHAR_MINUS) begin
                chk_step_ok = 1'b0;
            end
            for (int b = 0; b < SLOTS; b++) begin
                if ((IDX_W'(b) > r_chk_idx) && (6'(b) < r_radix)
                        && (sym_at(r_alph, IDX_W'(b)) == chk_sym)) begin
                    chk_step_ok = 1'b0;
                end
            end
        end
    end

    // Hold configuration and run the sweep after each write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix    <= '0;
            r_alph     <= '0;
            r_chk_busy <= 1'b0;
            r_chk_idx  <= '0;
            r_chk_ok   <= 1'b0;
            r_alpha_ok <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIX: r_radix          <= i_cfg_data[5:0];
                CFG_WORD0: r_alph[0*64 +: 64] <= i_cfg_data;
                CFG_WORD1: r_alph[1*64 +: 64] <= i_cfg_data;
                CFG_WORD2: r_alph[2*64 +: 64] <= i_cfg_data;
                CFG_WORD3: r_alph[3*64 +: 64] <= i_cfg_data;
                default: ;
            endcase
            r_chk_busy <= 1'b1;
            r_chk_idx  <= '0;
            r_chk_ok   <= 1'b1;
            r_alpha_ok <= 1'b0;
        end else if (r_chk_busy) begin
            r_chk_ok  <= r_chk_ok & chk_step_ok;
            r_chk_idx <= r_chk_idx + 1'b1;
            if (r_chk_idx == IDX_W'(SLOTS - 1)) begin
                r_chk_busy <= 1'b0;
                r_alpha_ok <= r_chk_ok & chk_step_ok & ~radix_bad;
            end
        end
    end

    // ---------------- datapath helpers ----------------
    assign mag_in   = s_axis_tdata[31] ? (33'h1_0000_0000 - {1'b0, s_axis_tdata})
                                       : {1'b0, s_axis_tdata};
    assign rem_sh   = {r_rem, r_quo[MAG_W-1]};
    assign q_bit    = (rem_sh >= r_radix);
    assign n_rem    = q_bit ? IDX_W'(rem_sh - r_radix) : IDX_W'(rem_sh);
    assign n_quo    = {r_quo[MAG_W-2:0], q_bit};
    assign bit_last = (r_bit == BIT_W'(MAG_W - 1));
    assign div_done = (n_quo == '0) || (r_nd == ND_W'(DIGITS - 1));
    assign out_free = !r_out_valid || m_axis_tready;
    assign ram_wdata = sym_at(r_alph, n_rem);
    assign ram_raddr = (r_nd == '0) ? '0 : r_nd - 1'b1;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer && r_alpha_ok) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (bit_last && div_done) n_state = r_neg ? ST_SIGN : ST_RD;
            end
            ST_SIGN: begin
                if (out_free) n_state = ST_RD;
            end
            ST_RD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) n_state = (r_nd == ND_W'(1)) ? ST_IDLE : ST_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs of the sequencer ----------------
    always_comb begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        out_load  = 1'b0;
        load_char = ram_rdata;
        load_last = 1'b0;
        unique case (r_state)
            ST_IDLE: in_ready = !r_chk_busy;
            ST_DIV:  ram_we   = bit_last;
            ST_SIGN: begin
                out_load  = out_free;
                load_char = CHAR_MINUS;
            end
            ST_RD: ;
            ST_EMIT: begin
                out_load  = out_free;
                load_last = (r_nd == ND_W'(1));
            end
            default: ;
        endcase
    end

    assign in_xfer = s_axis_tvalid && in_ready;

    // ---------------- sequencer registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_nd    <= '0;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_nd  <= '0;
                r_bit <= '0;
            end else if (r_state == ST_DIV) begin
                r_bit <= bit_last ? '0 : r_bit + 1'b1;
                if (bit_last) r_nd <= r_nd + 1'b1;
            end else if (r_state == ST_EMIT && out_free) begin
                r_nd <= r_nd - 1'b1;
            end
        end
    end

    // Shift the dividend and remainder one bit per cycle
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_quo <= mag_in;
            r_rem <= '0;
            r_neg <= s_axis_tdata[31];
        end else if (r_state == ST_DIV) begin
            r_quo <= n_quo;
            r_rem <= bit_last ? '0 : n_rem;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_char <= load_char;
            r_out_last <= load_last;
        end
    end

    // Digit store, written least significant digit first
    sirt_ram #(
        .WIDTH (8),
        .DEPTH (DIGITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_nd),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tlast  = r_out_last;

    // ---------------- assertions ----------------
    a_no_accept_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_busy |-> !s_axis_tready)
        else $error("value taken during alphabet check");

    a_digit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_nd < ND_W'(DIGITS)))
        else $error("digit store overrun");

    a_emit_has_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT || r_state == ST_RD) |-> (r_nd != '0))
        else $error("emit with empty digit store");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && load_last) |=> (r_state == ST_IDLE))
        else $error("sequencer busy after last character");

endmodule
